### sv/sict_pkg.sv
// ----------------------------------------------------------------------------
// sict_pkg
// Shared types and constants for the SYN intercept connection table.
// ----------------------------------------------------------------------------
package sict_pkg;

  // table geometry default
  localparam int unsigned TableDepthDef = 16;

  // configuration register reset values
  localparam logic [31:0] InitSeqRst = 32'd100;
  localparam logic [15:0] AdvWinRst  = 16'd155;

  // configuration port
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgInitSeq = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgAdvWin  = 1'b1;

  // stream payload widths
  localparam int unsigned InTdataW  = 136;
  localparam int unsigned InTuserW  = 2;
  localparam int unsigned OutTdataW = 88;
  localparam int unsigned OutTuserW = 3;

  // result action codes
  typedef enum logic [2:0] {
    ACT_FORWARD = 3'd0,
    ACT_DROP    = 3'd1,
    ACT_NEW     = 3'd2,
    ACT_RESEND  = 3'd3,
    ACT_FULL    = 3'd4
  } action_e;

  // control states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  // lookup word traveling down the cell row
  typedef struct packed {
    logic        valid;
    logic [63:0] key;
    logic [31:0] ports;
  } query_t;

  // match summary carried along with the lookup word
  typedef struct packed {
    logic        hit;
    logic        free;
    logic [31:0] hit_seq;
  } acc_t;

  // table write request, slot index travels beside it
  typedef struct packed {
    logic        en;
    logic [63:0] key;
    logic [31:0] ports;
    logic [31:0] seq;
  } wr_t;

  // one result word
  typedef struct packed {
    action_e     action;
    logic        fwd;
    logic        synack;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] win;
    logic [3:0]  idx;
  } result_t;

endpackage

### sv/sict_cell.sv
// ----------------------------------------------------------------------------
// sict_cell
// One table slot: holds a connection entry, compares the passing lookup word
// against it and hands the word and match summary on to the next slot.
// ----------------------------------------------------------------------------
module sict_cell #(
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CellIdx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sict_pkg::query_t    qry_i,
  input  sict_pkg::acc_t      acc_i,
  input  logic [IdxW-1:0]     hit_idx_i,
  input  logic [IdxW-1:0]     free_idx_i,
  input  sict_pkg::wr_t       wr_i,
  input  logic [IdxW-1:0]     wr_idx_i,
  output sict_pkg::query_t    qry_o,
  output sict_pkg::acc_t      acc_o,
  output logic [IdxW-1:0]     hit_idx_o,
  output logic [IdxW-1:0]     free_idx_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic             valid_q;
  logic [63:0]      key_q;
  logic [31:0]      ports_q;
  logic [31:0]      seq_q;
  logic             wr_sel;
  logic             match;

  logic             qvld_q;
  logic [63:0]      qkey_q;
  logic [31:0]      qports_q;
  sict_pkg::acc_t   acc_d, acc_q;
  logic [IdxW-1:0]  hit_idx_d, hit_idx_q;
  logic [IdxW-1:0]  free_idx_d, free_idx_q;

  assign wr_sel = wr_i.en && (wr_idx_i == MyIdx);

  // entry storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_sel) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      key_q   <= wr_i.key;
      ports_q <= wr_i.ports;
      seq_q   <= wr_i.seq;
    end
  end

  // compare and fold into the running summary
  assign match = valid_q && (key_q == qry_i.key) && (ports_q == qry_i.ports);

  always_comb begin
    acc_d      = acc_i;
    hit_idx_d  = hit_idx_i;
    free_idx_d = free_idx_i;
    if (!acc_i.hit && match) begin
      acc_d.hit     = 1'b1;
      acc_d.hit_seq = seq_q;
      hit_idx_d     = MyIdx;
    end
    if (!acc_i.free && !valid_q) begin
      acc_d.free = 1'b1;
      free_idx_d = MyIdx;
    end
  end

  // hand-off register toward the next slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qvld_q <= 1'b0;
    end else begin
      qvld_q <= qry_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    qkey_q     <= qry_i.key;
    qports_q   <= qry_i.ports;
    acc_q      <= acc_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign qry_o.valid = qvld_q;
  assign qry_o.key   = qkey_q;
  assign qry_o.ports = qports_q;
  assign acc_o       = acc_q;
  assign hit_idx_o   = hit_idx_q;
  assign free_idx_o  = free_idx_q;

endmodule

### sv/sict_chain.sv
// ----------------------------------------------------------------------------
// sict_chain
// Row of table slots; a lookup word enters slot 0, passes each slot's hand-off
// register in turn and leaves the last slot carrying the first match and first free slot.
// ----------------------------------------------------------------------------
module sict_chain #(
  parameter int unsigned TableDepth = sict_pkg::TableDepthDef,
  parameter int unsigned IdxW       = $clog2(TableDepth)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sict_pkg::query_t    qry_i,
  input  sict_pkg::wr_t       wr_i,
  input  logic [IdxW-1:0]     wr_idx_i,
  output sict_pkg::query_t    qry_o,
  output sict_pkg::acc_t      acc_o,
  output logic [IdxW-1:0]     hit_idx_o,
  output logic [IdxW-1:0]     free_idx_o
);

  sict_pkg::query_t qry_w      [TableDepth+1];
  sict_pkg::acc_t   acc_w      [TableDepth+1];
  logic [IdxW-1:0]  hit_idx_w  [TableDepth+1];
  logic [IdxW-1:0]  free_idx_w [TableDepth+1];

  // row entry: empty summary
  assign qry_w[0]      = qry_i;
  assign acc_w[0]      = '0;
  assign hit_idx_w[0]  = '0;
  assign free_idx_w[0] = '0;

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    sict_cell #(
      .IdxW    (IdxW),
      .CellIdx (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .qry_i      (qry_w[g]),
      .acc_i      (acc_w[g]),
      .hit_idx_i  (hit_idx_w[g]),
      .free_idx_i (free_idx_w[g]),
      .wr_i       (wr_i),
      .wr_idx_i   (wr_idx_i),
      .qry_o      (qry_w[g+1]),
      .acc_o      (acc_w[g+1]),
      .hit_idx_o  (hit_idx_w[g+1]),
      .free_idx_o (free_idx_w[g+1])
    );
  end

  assign qry_o      = qry_w[TableDepth];
  assign acc_o      = acc_w[TableDepth];
  assign hit_idx_o  = hit_idx_w[TableDepth];
  assign free_idx_o = free_idx_w[TableDepth];

endmodule

### sv/syn_intercept_connection_table.sv
// ----------------------------------------------------------------------------
// syn_intercept_connection_table
// Intercepts LAN SYNs, keeps a table of connections and builds SYN-ACK fields.
// ----------------------------------------------------------------------------
// One header summary word comes in on the s_axis channel; exactly one result
// word goes out on m_axis. Registers (initial sequence, advertised window)
// are written through cfg_we_i / cfg_idx_i / cfg_data_i; the user must write
// them only while the block idles, which the block itself does not enforce.
// A LAN SYN without ACK runs down the row of table slots, one slot per cycle;
// its result goes to the pending result register as it leaves the last slot
// and then on to the output register. The next word is taken only after that,
// so lookups do not overlap. Non-TCP and dropped words skip the row.
// A new word is accepted while the previous result still sits in the output
// register; if the receiver stalls, a finished result waits in the block and
// the input stays blocked until the output register frees.
// Reset empties the table at once (per-slot valid flags), restores register
// defaults and drops any word in flight.
// ----------------------------------------------------------------------------
module syn_intercept_connection_table #(
  parameter int unsigned TABLE_DEPTH = sict_pkg::TableDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [sict_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [sict_pkg::CfgDataW-1:0]   cfg_data_i,
  // header words in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // source_address, dest_address, source_port, dest_port, sequence_req,
  // syn_flag, ack_flag, zero fill
  input  logic [sict_pkg::InTdataW-1:0]   s_axis_tdata,
  // is_tcp, from_lan
  input  logic [sict_pkg::InTuserW-1:0]   s_axis_tuser,
  // result words out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // forward_packet, send_synack, synack_sequence, synack_acknowledge,
  // synack_window, entry_index, zero fill
  output logic [sict_pkg::OutTdataW-1:0]  m_axis_tdata,
  // action
  output logic [sict_pkg::OutTuserW-1:0]  m_axis_tuser
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);

  sict_pkg::state_e  state_q, state_d;
  logic [31:0]       init_seq_q;
  logic [15:0]       adv_win_q;

  logic              qvld_q;
  logic [63:0]       qkey_q;
  logic [31:0]       qports_q;
  logic [31:0]       qseq_q;

  sict_pkg::query_t  chain_in, chain_out;
  sict_pkg::acc_t    chain_acc;
  logic [IdxW-1:0]   hit_idx, free_idx;
  sict_pkg::wr_t     tbl_wr;
  logic [IdxW+3:0]   hit_idx_ext, free_idx_ext;

  sict_pkg::result_t res_q, res_d;
  logic              res_load;
  sict_pkg::result_t out_q;
  logic              out_vld_q;
  logic              out_load;

  logic              in_acc;
  logic              in_tcp, in_lan, in_syn, in_ack;
  logic              in_search;

  // input word fields
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign in_tcp    = s_axis_tuser[0];
  assign in_lan    = s_axis_tuser[1];
  assign in_syn    = s_axis_tdata[128];
  assign in_ack    = s_axis_tdata[129];
  assign in_search = in_tcp && in_lan && in_syn && !in_ack;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_seq_q <= sict_pkg::InitSeqRst;
      adv_win_q  <= sict_pkg::AdvWinRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sict_pkg::CfgInitSeq: init_seq_q <= cfg_data_i;
        sict_pkg::CfgAdvWin:  adv_win_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // lookup word register, valid for one cycle per search
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qvld_q <= 1'b0;
    end else begin
      qvld_q <= in_acc && in_search;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qkey_q   <= {s_axis_tdata[31:0], s_axis_tdata[63:32]};
      qports_q <= {s_axis_tdata[95:80], s_axis_tdata[79:64]};
      qseq_q   <= s_axis_tdata[127:96];
    end
  end

  assign chain_in.valid = qvld_q;
  assign chain_in.key   = qkey_q;
  assign chain_in.ports = qports_q;

  sict_chain #(
    .TableDepth (TABLE_DEPTH),
    .IdxW       (IdxW)
  ) u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .qry_i      (chain_in),
    .wr_i       (tbl_wr),
    .wr_idx_i   (free_idx),
    .qry_o      (chain_out),
    .acc_o      (chain_acc),
    .hit_idx_o  (hit_idx),
    .free_idx_o (free_idx)
  );

  assign hit_idx_ext  = {4'b0000, hit_idx};
  assign free_idx_ext = {4'b0000, free_idx};

  // control: classify, resolve the lookup, hand result to output register
  always_comb begin
    state_d       = state_q;
    res_d         = res_q;
    res_load      = 1'b0;
    out_load      = 1'b0;
    s_axis_tready = 1'b0;
    tbl_wr.en     = 1'b0;
    tbl_wr.key    = qkey_q;
    tbl_wr.ports  = qports_q;
    tbl_wr.seq    = qseq_q;
    unique case (state_q)
      sict_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc) begin
          res_d        = '0;
          res_d.action = sict_pkg::ACT_DROP;
          if (!in_tcp) begin
            res_d.action = sict_pkg::ACT_FORWARD;
            res_d.fwd    = 1'b1;
          end
          res_load = !in_search;
          state_d  = in_search ? sict_pkg::ST_SEARCH : sict_pkg::ST_FINISH;
        end
      end
      sict_pkg::ST_SEARCH: begin
        if (chain_out.valid) begin
          res_d    = '0;
          res_load = 1'b1;
          state_d  = sict_pkg::ST_FINISH;
          priority if (chain_acc.hit) begin
            res_d.action = sict_pkg::ACT_RESEND;
            res_d.synack = 1'b1;
            res_d.seq    = init_seq_q;
            res_d.ack    = chain_acc.hit_seq + 32'd1;
            res_d.win    = adv_win_q;
            res_d.idx    = hit_idx_ext[3:0];
          end else if (!chain_acc.free) begin
            res_d.action = sict_pkg::ACT_FULL;
            res_d.fwd    = 1'b1;
          end else begin
            res_d.action = sict_pkg::ACT_NEW;
            res_d.fwd    = 1'b1;
            res_d.synack = 1'b1;
            res_d.seq    = init_seq_q;
            res_d.ack    = qseq_q + 32'd1;
            res_d.win    = adv_win_q;
            res_d.idx    = free_idx_ext[3:0];
            tbl_wr.en    = 1'b1;
          end
        end
      end
      sict_pkg::ST_FINISH: begin
        if (!out_vld_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = sict_pkg::ST_IDLE;
        end
      end
      default: state_d = sict_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sict_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pending result
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.action;
  assign m_axis_tdata  = {2'b00, out_q.idx, out_q.win, out_q.ack, out_q.seq,
                          out_q.synack, out_q.fwd};

`ifndef NO_ASSERTIONS
  // a lookup only completes while the controller waits for it
  a_chain_done_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_out.valid |-> state_q == sict_pkg::ST_SEARCH)
    else $error("lookup completed outside search state");

  // no slot is filled for a connection already in the table
  a_no_dup_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_wr.en |-> (!chain_acc.hit && chain_acc.free))
    else $error("table write despite hit or full table");

  // output register is never overwritten while its word waits
  a_no_out_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_vld_q || m_axis_tready))
    else $error("output word overwritten");

  // synack fields only for new or resent connections
  a_synack_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.synack) |->
      (out_q.action == sict_pkg::ACT_NEW || out_q.action == sict_pkg::ACT_RESEND))
    else $error("synack flagged on wrong action");

  // an accepted search word enters the slot row on the next cycle
  a_search_injected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_search) |=> qvld_q && state_q == sict_pkg::ST_SEARCH)
    else $error("search word not injected");
`endif

endmodule
